### rtl/hvcbs_pkg.sv
// ----------------------------------------------------------------------------
// hvcbs_pkg
// Shared constants, codes and controller/datapath types for the color
// boundary search block.
// ----------------------------------------------------------------------------
package hvcbs_pkg;

    localparam int COLS_MAX   = 1024;
    localparam int MAX_HEIGHT = 1024;

    // field and register widths
    localparam int POS_W  = 10;
    localparam int DIM_W  = 11;
    localparam int FF_W   = 8;
    localparam int FILL_W = DIM_W + FF_W;
    localparam int SH_W   = 4;
    localparam int KIND_W = 2;

    // column store word: {seen, top row, bottom row}
    localparam int WORD_W = 1 + 2 * POS_W;

    localparam logic [SH_W-1:0] SHIFT_MAX = SH_W'(10);

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd2;

    // result kinds
    localparam logic RES_ROW   = 1'b0;
    localparam logic RES_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_ROW_END,
        ST_QRY_RD,
        ST_QRY_OUT
    } hvcbs_state_t;

    typedef struct packed {
        logic capture;
        logic clear_start;
        logic clear_step;
        logic rd_query;
        logic pix_write;
        logic row_end;
        logic qry_load;
    } hvcbs_cmd_t;

    typedef struct packed {
        logic pix_live;
        logic row_last;
        logic clear_last;
        logic out_full;
    } hvcbs_stat_t;

endpackage

### rtl/hvcbs_if.sv
// ----------------------------------------------------------------------------
// hvcbs_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface hvcbs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       is_target;
    logic [9:0] column;

    modport source (output valid, kind, is_target, column, input ready);
    modport sink   (input valid, kind, is_target, column, output ready);
endinterface

interface hvcbs_result_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [9:0] index;
    logic [9:0] first_pos;
    logic [9:0] second_pos;
    logic       first_marked;
    logic       second_marked;

    modport source (output valid, result_kind, index, first_pos, second_pos,
                    first_marked, second_marked, input ready);
    modport sink   (input valid, result_kind, index, first_pos, second_pos,
                    first_marked, second_marked, output ready);
endinterface

### rtl/hvcbs_ram.sv
// ----------------------------------------------------------------------------
// hvcbs_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hvcbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hvcbs_ctrl.sv
// ----------------------------------------------------------------------------
// hvcbs_ctrl
// Sequencer: accepts items, steps the column store read-modify-write,
// row-end evaluation, queries and the clearing pass.
// ----------------------------------------------------------------------------
module hvcbs_ctrl
    import hvcbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] in_kind,
    input  hvcbs_stat_t       stat,
    output logic              in_ready,
    output hvcbs_cmd_t        cmd
);

    hvcbs_state_t state_reg;
    hvcbs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (in_kind)
                        KIND_PIXEL:
                        begin
                            // pixels past the last row are dropped
                            if (stat.pix_live)
                            begin
                                state_next = ST_PIX_RD;
                            end
                        end
                        KIND_QUERY:
                        begin
                            state_next = ST_QRY_RD;
                        end
                        KIND_FRAME:
                        begin
                            cmd.clear_start = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PIX_RD:
            begin
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                cmd.pix_write = 1'b1;
                state_next    = stat.row_last ? ST_ROW_END : ST_IDLE;
            end
            ST_ROW_END:
            begin
                if (!stat.out_full)
                begin
                    cmd.row_end = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_QRY_RD:
            begin
                cmd.rd_query = 1'b1;
                state_next   = ST_QRY_OUT;
            end
            ST_QRY_OUT:
            begin
                // keep the read address so the data holds while stalled
                cmd.rd_query = 1'b1;
                if (!stat.out_full)
                begin
                    cmd.qry_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/hvcbs_dp.sv
// ----------------------------------------------------------------------------
// hvcbs_dp
// Datapath: row tracking registers, column store, row-end fill test and
// reflection cutoff, result register.
// ----------------------------------------------------------------------------
module hvcbs_dp
    import hvcbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  hvcbs_cmd_t        cmd,
    output hvcbs_stat_t       stat,
    input  logic [DIM_W-1:0]  frame_width,
    input  logic [DIM_W-1:0]  frame_height,
    input  logic [FF_W-1:0]   fill_factor,
    input  logic [SH_W-1:0]   shrink_shift,
    input  logic              is_target,
    input  logic [POS_W-1:0]  column,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              result_kind,
    output logic [POS_W-1:0]  index,
    output logic [POS_W-1:0]  first_pos,
    output logic [POS_W-1:0]  second_pos,
    output logic              first_marked,
    output logic              second_marked
);

    // row and frame state
    logic [POS_W-1:0]  col_count_reg, col_count_next;
    logic [DIM_W-1:0]  row_count_reg, row_count_next;
    logic [POS_W-1:0]  left_reg, left_next;
    logic [POS_W-1:0]  right_reg, right_next;
    logic              row_seen_reg, row_seen_next;
    logic [DIM_W-1:0]  tcount_reg, tcount_next;
    logic [POS_W-1:0]  max_span_reg, max_span_next;
    logic              reflect_ok_reg, reflect_ok_next;
    logic [POS_W-1:0]  clr_addr_reg, clr_addr_next;

    // captured item
    logic              tgt_reg, tgt_next;
    logic [POS_W-1:0]  qcol_reg, qcol_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [POS_W-1:0]  out_index_reg, out_index_next;
    logic [POS_W-1:0]  out_first_reg, out_first_next;
    logic [POS_W-1:0]  out_second_reg, out_second_next;
    logic              out_fm_reg, out_fm_next;
    logic              out_sm_reg, out_sm_next;

    // column store
    logic              ram_we;
    logic [POS_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [POS_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              rd_seen;
    logic [POS_W-1:0]  rd_top;
    logic [POS_W-1:0]  rd_bot;

    // effective sizes and row-end terms
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [DIM_W-1:0]  w_last;
    logic [DIM_W-1:0]  h_last;
    logic [POS_W-1:0]  span;
    logic [FILL_W-1:0] fill_prod;
    logic              row_ok;
    logic [POS_W-1:0]  max_new;
    logic [POS_W-1:0]  lim;
    logic              left_mark;
    logic              right_mark;
    logic              qry_in;
    logic [POS_W-1:0]  q_top;
    logic [POS_W-1:0]  q_bot;

    hvcbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (COLS_MAX)
    ) u_col_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_seen = ram_rdata[WORD_W-1];
    assign rd_top  = ram_rdata[2*POS_W-1:POS_W];
    assign rd_bot  = ram_rdata[POS_W-1:0];

    assign ram_raddr = cmd.rd_query ? qcol_reg : col_count_reg;

    assign w_eff = (frame_width == '0) ? DIM_W'(1) :
                   ((frame_width > DIM_W'(COLS_MAX)) ? DIM_W'(COLS_MAX) : frame_width);
    assign h_eff = (frame_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height;
    assign w_last = w_eff - DIM_W'(1);
    // wraps to all ones for a zero height, which no stored row can match
    assign h_last = h_eff - DIM_W'(1);

    assign span      = right_reg - left_reg;
    // fill test uses the fill factor in force at the end of the row
    assign fill_prod = FILL_W'(tcount_reg) * FILL_W'(fill_factor);
    assign row_ok    = row_seen_reg && (right_reg >= left_reg) &&
                       (fill_prod > FILL_W'(span));
    assign max_new = (row_ok && (span > max_span_reg)) ? span : max_span_reg;
    assign lim     = (shrink_shift > SHIFT_MAX) ? '0 : (max_new >> shrink_shift);
    assign left_mark  = (left_reg != '0) && ({1'b0, left_reg} < w_last);
    assign right_mark = (right_reg != '0) && ({1'b0, right_reg} < w_last);

    assign qry_in = {1'b0, qcol_reg} < w_eff;
    assign q_top  = qry_in ? rd_top : '0;
    assign q_bot  = qry_in ? rd_bot : '0;

    assign stat.pix_live   = row_count_reg < h_eff;
    assign stat.row_last   = ({1'b0, col_count_reg} + DIM_W'(1)) >= w_eff;
    assign stat.clear_last = (clr_addr_reg == POS_W'(COLS_MAX - 1));
    assign stat.out_full   = out_valid_reg && !out_ready;

    always_comb
    begin
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        row_seen_next   = row_seen_reg;
        tcount_next     = tcount_reg;
        max_span_next   = max_span_reg;
        reflect_ok_next = reflect_ok_reg;
        clr_addr_next   = clr_addr_reg;
        tgt_next        = tgt_reg;
        qcol_next       = qcol_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_index_next  = out_index_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_fm_next     = out_fm_reg;
        out_sm_next     = out_sm_reg;
        ram_we          = 1'b0;
        ram_waddr       = col_count_reg;
        ram_wdata       = '0;

        if (cmd.capture)
        begin
            tgt_next  = is_target;
            qcol_next = column;
        end

        if (cmd.clear_start)
        begin
            col_count_next  = '0;
            row_count_next  = '0;
            left_next       = '0;
            right_next      = '0;
            row_seen_next   = 1'b0;
            tcount_next     = '0;
            max_span_next   = '0;
            reflect_ok_next = 1'b1;
            clr_addr_next   = '0;
        end

        if (cmd.clear_step)
        begin
            ram_we        = 1'b1;
            ram_waddr     = clr_addr_reg;
            clr_addr_next = clr_addr_reg + POS_W'(1);
        end

        if (cmd.pix_write)
        begin
            ram_we = 1'b1;
            if (tgt_reg)
            begin
                right_next    = col_count_reg;
                row_seen_next = 1'b1;
                // targets seen in this row
                tcount_next   = tcount_reg + DIM_W'(1);
                ram_wdata = {1'b1, rd_top,
                             reflect_ok_reg ? row_count_reg[POS_W-1:0] : rd_bot};
            end
            else
            begin
                if (!row_seen_reg)
                begin
                    left_next = col_count_reg;
                end
                ram_wdata = {rd_seen, rd_seen ? rd_top : row_count_reg[POS_W-1:0], rd_bot};
            end
            col_count_next = stat.row_last ? '0 : (col_count_reg + POS_W'(1));
        end

        if (cmd.row_end)
        begin
            max_span_next = max_new;
            if (row_ok && reflect_ok_reg)
            begin
                if (span < lim)
                begin
                    reflect_ok_next = 1'b0;
                end
                out_fm_next = left_mark;
                out_sm_next = right_mark;
            end
            else
            begin
                out_fm_next = 1'b0;
                out_sm_next = 1'b0;
            end
            out_valid_next  = 1'b1;
            out_kind_next   = RES_ROW;
            out_index_next  = row_count_reg[POS_W-1:0];
            out_first_next  = left_reg;
            out_second_next = right_reg;
            row_count_next  = row_count_reg + DIM_W'(1);
            left_next       = '0;
            right_next      = '0;
            tcount_next     = '0;
            row_seen_next   = 1'b0;
        end

        if (cmd.qry_load)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = RES_QUERY;
            out_index_next  = qcol_reg;
            out_first_next  = q_top;
            out_second_next = q_bot;
            out_fm_next     = (q_top != '0) && ({1'b0, q_top} != h_last);
            out_sm_next     = (q_bot != '0) && ({1'b0, q_bot} != h_last);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            row_seen_reg   <= 1'b0;
            tcount_reg     <= '0;
            max_span_reg   <= '0;
            reflect_ok_reg <= 1'b1;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            row_seen_reg   <= row_seen_next;
            tcount_reg     <= tcount_next;
            max_span_reg   <= max_span_next;
            reflect_ok_reg <= reflect_ok_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg        <= tgt_next;
        qcol_reg       <= qcol_next;
        out_kind_reg   <= out_kind_next;
        out_index_reg  <= out_index_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_fm_reg     <= out_fm_next;
        out_sm_reg     <= out_sm_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign index         = out_index_reg;
    assign first_pos     = out_first_reg;
    assign second_pos    = out_second_reg;
    assign first_marked  = out_fm_reg;
    assign second_marked = out_sm_reg;

endmodule

### rtl/hv_color_boundary_search.sv
// ----------------------------------------------------------------------------
// hv_color_boundary_search
// Marks the horizontal and vertical boundaries of one color class in a
// raster of pre-classified pixels, with per-column top/bottom queries.
// ----------------------------------------------------------------------------
// A pixel passes through accept, column store read and column store write, and
// the last pixel of a row then goes on to the row-end evaluation, which waits
// while the output register is full. A column query passes through accept,
// column store read and output load, which also waits on a full output register.
// After reset and after every start-frame item the column store is swept clear,
// one column per cycle, during which no item is accepted; configuration writes
// are taken at any time. A finished result waits in an output register while
// further items that give no result are accepted.
module hv_color_boundary_search
    import hvcbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    hvcbs_item_if.sink            item,
    hvcbs_result_if.source        result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILL_FACTOR  = 2'd2;
    localparam logic [1:0] REG_SHRINK_SHIFT = 2'd3;

    logic [DIM_W-1:0] frame_width_reg, frame_width_next;
    logic [DIM_W-1:0] frame_height_reg, frame_height_next;
    logic [FF_W-1:0]  fill_factor_reg, fill_factor_next;
    logic [SH_W-1:0]  shrink_shift_reg, shrink_shift_next;
    logic             cfg_write;
    logic [1:0]       reg_sel;

    hvcbs_cmd_t  cmd;
    hvcbs_stat_t stat;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        fill_factor_next  = fill_factor_reg;
        shrink_shift_next = shrink_shift_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                REG_FRAME_WIDTH:  frame_width_next  = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[DIM_W-1:0];
                REG_FILL_FACTOR:  fill_factor_next  = pwdata[FF_W-1:0];
                REG_SHRINK_SHIFT: shrink_shift_next = pwdata[SH_W-1:0];
                default:          frame_width_next  = frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, frame_width_reg};
            REG_FRAME_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, frame_height_reg};
            REG_FILL_FACTOR:  prdata = {{(32-FF_W){1'b0}}, fill_factor_reg};
            REG_SHRINK_SHIFT: prdata = {{(32-SH_W){1'b0}}, shrink_shift_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
            fill_factor_reg  <= FF_W'(9);
            shrink_shift_reg <= SH_W'(4);
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            fill_factor_reg  <= fill_factor_next;
            shrink_shift_reg <= shrink_shift_next;
        end
    end

    hvcbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_kind  (item.kind),
        .stat     (stat),
        .in_ready (item.ready),
        .cmd      (cmd)
    );

    hvcbs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .fill_factor   (fill_factor_reg),
        .shrink_shift  (shrink_shift_reg),
        .is_target     (item.is_target),
        .column        (item.column),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .result_kind   (result.result_kind),
        .index         (result.index),
        .first_pos     (result.first_pos),
        .second_pos    (result.second_pos),
        .first_marked  (result.first_marked),
        .second_marked (result.second_marked)
    );

    // a start-frame transaction always begins the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.kind == KIND_FRAME) |=> !item.ready)
        else $error("input accepted right after a start-frame transaction");

    // the clearing pass hands back to idle after its last column
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear_step && stat.clear_last) |=> item.ready)
        else $error("block not ready after the clearing pass");

    // a row evaluation always leaves a row result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_end |=> (result.valid && result.result_kind == RES_ROW))
        else $error("row evaluation produced no row result");

    // a marked position is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.first_marked || result.second_marked)) |->
        ((!result.first_marked || result.first_pos != '0) &&
         (!result.second_marked || result.second_pos != '0)))
        else $error("boundary mark on position zero");

endmodule

### bench/hvcbs_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvcbs_tb_pkg
// Register indexes and item codes shared by the boundary search bench
// stimulus and its checker.
// ----------------------------------------------------------------------------
package hvcbs_tb_pkg;

    // register i sits at byte address 4*i
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_FILL_FACTOR,
        REG_SHRINK_SHIFT
    } reg_index_t;

    // the one kind code the block does not define
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int unsigned DEF_FRAME_WIDTH  = 640;
    localparam int unsigned DEF_FRAME_HEIGHT = 480;
    localparam int unsigned DEF_FILL_FACTOR  = 9;
    localparam int unsigned DEF_SHRINK_SHIFT = 4;

endpackage

### bench/hvcbs_boundary_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvcbs_boundary_checker
// Watches the item, result and register channels of the boundary search
// block, predicts every row and column result and compares them in order.
// ----------------------------------------------------------------------------
module hvcbs_boundary_checker
    import hvcbs_pkg::*;
    import hvcbs_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hvcbs_item_if       item_mon,
    hvcbs_result_if     result_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_results
);

    typedef struct packed {
        logic       result_kind;
        logic [9:0] index;
        logic [9:0] first_pos;
        logic [9:0] second_pos;
        logic       first_marked;
        logic       second_marked;
    } boundary_mark_t;

    boundary_mark_t expected_marks[$];

    // register shadow
    int unsigned cfg_width;
    int unsigned cfg_height;
    int unsigned cfg_fill;
    int unsigned cfg_shift;

    // search state
    logic [POS_W-1:0] top_rows    [COLS_MAX];
    logic [POS_W-1:0] bottom_rows [COLS_MAX];
    logic             column_seen [COLS_MAX];
    int unsigned      column_count;
    int unsigned      row_count;
    int unsigned      left_pos;
    int unsigned      right_pos;
    int unsigned      target_count;
    int unsigned      max_span;
    logic             row_seen;
    logic             reflect_ok;

    task automatic clear_search();
        top_rows     = '{default: '0};
        bottom_rows  = '{default: '0};
        column_seen  = '{default: 1'b0};
        column_count = 0;
        row_count    = 0;
        left_pos     = 0;
        right_pos    = 0;
        target_count = 0;
        max_span     = 0;
        row_seen     = 1'b0;
        reflect_ok   = 1'b1;
    endtask

    task automatic advance_search(input logic [1:0] kind, input logic tgt,
                                  input logic [9:0] col);
        int unsigned    w;
        int unsigned    h;
        int unsigned    c;
        int unsigned    t;
        int unsigned    b;
        int unsigned    span;
        int unsigned    lim;
        boundary_mark_t m;
        w = (cfg_width == 0) ? 1 : ((cfg_width > COLS_MAX) ? COLS_MAX : cfg_width);
        h = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
        m = '0;
        if (kind == KIND_FRAME)
        begin
            clear_search();
        end
        else if (kind == KIND_QUERY)
        begin
            m.result_kind = RES_QUERY;
            m.index       = col;
            // columns outside the active width answer all zero
            if (col < w)
            begin
                t = 32'(top_rows[col]);
                b = 32'(bottom_rows[col]);
                m.first_pos     = t[9:0];
                m.second_pos    = b[9:0];
                m.first_marked  = (t != 0) && (t != h - 1);
                m.second_marked = (b != 0) && (b != h - 1);
            end
            expected_marks.push_back(m);
        end
        else if (kind == KIND_PIXEL && row_count < h)
        begin
            c = column_count;
            if (tgt)
            begin
                right_pos = c;
                if (c < COLS_MAX)
                begin
                    if (reflect_ok)
                        bottom_rows[c[9:0]] = row_count[9:0];
                    column_seen[c[9:0]] = 1'b1;
                end
                row_seen = 1'b1;
                target_count++;
            end
            else
            begin
                if (!row_seen)
                    left_pos = c;
                if (c < COLS_MAX && !column_seen[c[9:0]])
                    top_rows[c[9:0]] = row_count[9:0];
            end
            column_count = c + 1;
            if (column_count >= w)
            begin
                span = (right_pos - left_pos) & 32'hFFFF;
                if (target_count != 0 && right_pos >= left_pos
                    && target_count * cfg_fill > span)
                begin
                    if (span > max_span)
                        max_span = span;
                    // once a row falls under the shrink limit, later rows of the frame get no marks
                    if (reflect_ok)
                    begin
                        lim = (cfg_shift > SHIFT_MAX) ? 0 : (max_span >> cfg_shift);
                        if (span < lim)
                            reflect_ok = 1'b0;
                        m.first_marked  = (left_pos != 0) && (left_pos < w - 1);
                        m.second_marked = (right_pos != 0) && (right_pos < w - 1);
                    end
                end
                m.result_kind = RES_ROW;
                m.index       = row_count[9:0];
                m.first_pos   = left_pos[9:0];
                m.second_pos  = right_pos[9:0];
                expected_marks.push_back(m);
                row_count++;
                column_count = 0;
                left_pos     = 0;
                right_pos    = 0;
                target_count = 0;
                row_seen     = 1'b0;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        boundary_mark_t want;
        if (!rst_n)
        begin
            cfg_width  = DEF_FRAME_WIDTH;
            cfg_height = DEF_FRAME_HEIGHT;
            cfg_fill   = DEF_FILL_FACTOR;
            cfg_shift  = DEF_SHRINK_SHIFT;
            clear_search();
            expected_marks.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_FRAME_WIDTH:  cfg_width  = 32'(pwdata[10:0]);
                    REG_FRAME_HEIGHT: cfg_height = 32'(pwdata[10:0]);
                    REG_FILL_FACTOR:  cfg_fill   = 32'(pwdata[7:0]);
                    REG_SHRINK_SHIFT: cfg_shift  = 32'(pwdata[3:0]);
                    default: ;
                endcase
            end
            if (item_mon.valid && item_mon.ready)
                advance_search(item_mon.kind, item_mon.is_target, item_mon.column);
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_marks.size() == 0)
                begin
                    $error("result with nothing expected: result_kind %0d index %0d",
                           result_mon.result_kind, result_mon.index);
                    fail_count++;
                end
                else
                begin
                    want = expected_marks.pop_front();
                    check_field("result_kind", 32'(want.result_kind),
                                32'(result_mon.result_kind));
                    check_field("index", 32'(want.index), 32'(result_mon.index));
                    check_field("first_pos", 32'(want.first_pos),
                                32'(result_mon.first_pos));
                    check_field("second_pos", 32'(want.second_pos),
                                32'(result_mon.second_pos));
                    check_field("first_marked", 32'(want.first_marked),
                                32'(result_mon.first_marked));
                    check_field("second_marked", 32'(want.second_marked),
                                32'(result_mon.second_marked));
                end
            end
        end
        pending_results = expected_marks.size();
    end

endmodule

### bench/tb_hv_color_boundary_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hv_color_boundary_search
// Drives frames of classified pixels, column queries and register settings
// into the boundary search block under random source and sink stalls; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_hv_color_boundary_search;
    import hvcbs_pkg::*;
    import hvcbs_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_results;
    int cycle_count;
    int sent_items;
    int gap_mode;

    hvcbs_item_if   item_ch();
    hvcbs_result_if result_ch();

    hv_color_boundary_search dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hvcbs_boundary_checker boundary_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_mon        (item_ch),
        .result_mon      (result_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result sink: switches between always ready, light and heavy back-pressure
    initial
    begin
        int mode;
        int hold;
        int stall;
        mode  = 0;
        hold  = 0;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                mode = $urandom_range(0, 2);
                hold = $urandom_range(50, 400);
            end
            hold--;
            if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        if ($urandom_range(0, 15) == 0)
                        begin
                            stall = $urandom_range(8, 40);
                            result_ch.ready <= 1'b0;
                        end
                        else
                            result_ch.ready <= 1'($urandom_range(0, 1));
                    end
                endcase
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_mode == 0 || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic tgt,
                             input logic [9:0] col);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= kind;
        item_ch.is_target <= tgt;
        item_ch.column    <= col;
        do @(posedge clk); while (!item_ch.ready);
        if (kind != KIND_UNUSED)
            sent_items++;
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int w, input int h, input int fill, input int shift);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_FILL_FACTOR, fill);
        write_reg(REG_SHRINK_SHIFT, shift);
    endtask

    task automatic run_frame_phase();
        int   w;
        int   h;
        int   fill;
        int   shift;
        int   eff_w;
        int   eff_h;
        int   rows;
        int   start;
        int   len;
        int   from_mid;
        int   k;
        int   r;
        bit   blob;
        bit   holes;
        logic tgt;
        gap_mode = int'($urandom_range(0, 2) != 0);
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            k = $urandom_range(0, 3);
            w = (k == 3) ? $urandom_range(17, 40) : k;
        end
        else
            w = $urandom_range(2, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        r = $urandom_range(0, 9);
        fill = (r == 0) ? 0 : (r == 1) ? 255 : (r == 2) ? $urandom_range(0, 255)
             : $urandom_range(1, 6);
        shift = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 15);
        configure(w, h, fill, shift);
        send_item(KIND_FRAME, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
        eff_w = (w == 0) ? 1 : w;
        eff_h = h;
        blob  = 1'($urandom_range(0, 1));
        holes = ($urandom_range(0, 2) == 0);

        // width lowered in the middle of a row: the row ends at the next pixel
        if ($urandom_range(0, 7) == 0 && eff_w > 2 && eff_h > 0)
        begin
            k = $urandom_range(1, eff_w - 1);
            repeat (k) send_item(KIND_PIXEL, 1'($urandom_range(0, 1)),
                                 10'($urandom_range(0, 1023)));
            eff_w = $urandom_range(1, k);
            settle();
            write_reg(REG_FRAME_WIDTH, eff_w);
        end

        rows = (eff_h == 0 ? 1 : eff_h) + int'($urandom_range(0, 3) == 0);
        for (int row = 0; row < rows; row++)
        begin
            if (blob)
            begin
                from_mid = (2 * row + 1 > rows) ? 2 * row + 1 - rows : rows - 2 * row - 1;
                len      = eff_w - (eff_w * from_mid) / rows;
                start    = (eff_w - len) / 2 + $urandom_range(0, 1);
            end
            else
            begin
                start = $urandom_range(0, eff_w - 1);
                len   = $urandom_range(0, eff_w - start);
            end
            for (int c = 0; c < eff_w; c++)
            begin
                if ($urandom_range(0, 29) == 0)
                    send_item(KIND_QUERY, 1'($urandom_range(0, 1)),
                              10'($urandom_range(0, eff_w)));
                if ($urandom_range(0, 59) == 0)
                    send_item(KIND_UNUSED, 1'($urandom_range(0, 1)),
                              10'($urandom_range(0, 1023)));
                if ($urandom_range(0, 299) == 0)
                    send_item(KIND_FRAME, 1'($urandom_range(0, 1)),
                              10'($urandom_range(0, 1023)));
                tgt = (c >= start && c < start + len && !(holes && $urandom_range(0, 5) == 0))
                      || $urandom_range(0, 19) == 0;
                send_item(KIND_PIXEL, tgt, 10'($urandom_range(0, 1023)));
            end
        end
        for (int c = 0; c < eff_w && c < 64; c++)
            send_item(KIND_QUERY, 1'($urandom_range(0, 1)), 10'(c));
        repeat (2) send_item(KIND_QUERY, 1'($urandom_range(0, 1)),
                             10'($urandom_range(0, 1023)));
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.kind      <= KIND_PIXEL;
        item_ch.is_target <= 1'b0;
        item_ch.column    <= '0;
        sent_items  = 0;
        gap_mode    = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: last column inside the default width and the first outside
        send_item(KIND_QUERY, 1'b0, 10'd639);
        send_item(KIND_QUERY, 1'b1, 10'd640);
        send_item(KIND_UNUSED, 1'b1, 10'h3FF);

        // small directed frame, one pixel past the last row
        configure(4, 3, 1, 0);
        send_item(KIND_FRAME, 1'b0, 10'd0);
        send_item(KIND_PIXEL, 1'b0, 10'd0);
        send_item(KIND_PIXEL, 1'b1, 10'd0);
        send_item(KIND_PIXEL, 1'b1, 10'd0);
        send_item(KIND_PIXEL, 1'b0, 10'd0);
        send_item(KIND_PIXEL, 1'b1, 10'h3FF);
        send_item(KIND_PIXEL, 1'b1, 10'h3FF);
        send_item(KIND_PIXEL, 1'b1, 10'h3FF);
        send_item(KIND_PIXEL, 1'b1, 10'h3FF);
        send_item(KIND_PIXEL, 1'b0, 10'd0);
        send_item(KIND_PIXEL, 1'b0, 10'd0);
        send_item(KIND_PIXEL, 1'b1, 10'd0);
        send_item(KIND_PIXEL, 1'b1, 10'd0);
        send_item(KIND_PIXEL, 1'b1, 10'd0);
        send_item(KIND_QUERY, 1'b0, 10'd0);
        send_item(KIND_QUERY, 1'b0, 10'd1);
        send_item(KIND_QUERY, 1'b1, 10'd3);
        send_item(KIND_QUERY, 1'b0, 10'd4);
        send_item(KIND_QUERY, 1'b1, 10'h3FF);

        while (sent_items < RANDOM_ITEMS)
            run_frame_phase();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
